// ===== sv/sprp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the semitone pitch ratio core: constants, state codes.
// No dependencies.
package sprp_pkg;
    localparam int VOICES     = 32;
    localparam int VOICE_W    = 5;
    localparam int SUM_W      = 18;
    localparam logic [SUM_W-1:0] RESET_SUM = 18'd25574;
    localparam logic [17:0] RATIO_MAX = 18'd131072;
    localparam logic [25:0] ONE_Q20  = 26'd1048576;
    // ceil(2^27 / 3): floor(n * DIV3_RECIP >> 27) == n / 3 for n < 2^27
    localparam logic [25:0] DIV3_RECIP = 26'd44739243;

    typedef enum logic [3:0] {
        ST_IDLE, ST_GMUL, ST_GDIV, ST_SUM, ST_ARG, ST_POLY, ST_PEND, ST_RDIV, ST_OUT
    } t_state;

    function automatic logic [25:0] poly_coef(input logic [2:0] k);
        case (k)
            3'd0:    poly_coef = 26'd726817;
            3'd1:    poly_coef = 26'd251896;
            3'd2:    poly_coef = 26'd58200;
            3'd3:    poly_coef = 26'd10085;
            3'd4:    poly_coef = 26'd1398;
            3'd5:    poly_coef = 26'd162;
            default: poly_coef = 26'd0;
        endcase
    endfunction
endpackage

// ===== sv/semitone_pitch_ratio_portamento_core.sv =====
`timescale 1ns / 1ps
// Top level of the semitone pitch ratio core with portamento.
// Depends on sprp_pkg.
//
// One beat in, one beat out. Each beat passes through the glide product, the
// glide divide, the sum, the argument, the polynomial and the reciprocal divide in
// that order: the glide quotient runs through a restoring divider one bit a cycle
// (only when a glide is active), the glide product, the argument and the five
// Horner steps plus the final product share one 34x34 signed multiplier (the
// Horner steps only when the sum changed), and a negative sum then adds a restoring
// divide for the reciprocal. The last sums per voice sit in flip-flops with reset.
// The block takes no beat while one is at work or its result waits.
module semitone_pitch_ratio_portamento_core
    import sprp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // voice[4:0], target_note[20:5], previous_note[36:21], glide_length[44:37],
    // glide_count[60:45], extra_offset[76:61], bend_amount[92:77], zero fill
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pitch_ratio[17:0], update_issued[18], clamped[19], glide_note[35:20], fill
    output logic [39:0] m_axis_tdata
);
    t_state r_state, n_state;

    logic [VOICE_W-1:0]        r_voice;
    logic signed [15:0]        r_target, r_prev, r_offs, r_bend, r_note;
    logic [7:0]                r_len;
    logic [15:0]               r_cnt;
    logic [SUM_W-1:0]          r_last [VOICES];
    logic signed [SUM_W-1:0]   r_sum;
    logic [63:0]               r_acc;   // dividend / quotient shift register
    logic [37:0]               r_rem;   // divider remainder
    logic [25:0]               r_a;     // polynomial argument, Q.20
    logic [32:0]               r_v;     // Horner accumulator, Q.20
    logic [37:0]               r_p;     // polynomial value, reciprocal divisor
    logic [5:0]                r_step;
    logic                      r_neg;
    logic [17:0]               r_ratio;
    logic                      r_upd, r_clamp;

    // Restoring divider step: remainder shift and trial subtract
    logic [37:0] divisor;
    logic [38:0] div_shift, div_diff;
    logic        div_ge;
    always_comb begin
        divisor   = (r_state == ST_GDIV) ? 38'(r_len) : r_p;
        div_shift = {r_rem, r_acc[63]};
        div_diff  = div_shift - {1'b0, divisor};
        div_ge    = (div_shift >= {1'b0, divisor});
    end

    logic [17:0] mag;
    logic [SUM_W-1:0] sum_next;
    logic [23:0] quo_u;
    logic signed [24:0] quo_s;
    always_comb begin
        mag = r_sum[SUM_W-1] ? 18'(-r_sum) : 18'(r_sum);
        sum_next = 18'(18'(signed'(r_note)) + 18'(signed'(r_offs)) + 18'(signed'(r_bend)));
        // glide quotient including the bit of the current step
        quo_u = {r_acc[22:0], div_ge};
        quo_s = r_neg ? -25'(quo_u) : 25'(quo_u);
    end

    // Shared multiplier: operand pair selected by state
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    always_comb begin
        if (r_state == ST_GMUL) begin
            mul_a = 34'(signed'(17'(r_target) - 17'(r_prev)));
            mul_b = 34'(signed'({1'b0, r_cnt}));
        end else if (r_state == ST_ARG) begin
            // (|sum| * 1024 + 1) / 3 by reciprocal
            mul_a = signed'(34'({mag, 10'd0} + 28'd1));
            mul_b = signed'(34'(DIV3_RECIP));
        end else begin
            mul_a = signed'({1'b0, r_v});
            mul_b = 34'(signed'({1'b0, r_a}));
        end
        mul_p = mul_a * mul_b;
    end

    // Product rounded back to Q.20, polynomial value and reciprocal dividend
    logic [37:0] prod_rnd, p_next, rdiv_num;
    always_comb begin
        prod_rnd = 38'((mul_p[58:0] + 59'd524288) >> 20);
        p_next   = prod_rnd + 38'(ONE_Q20);
        rdiv_num = (38'd1 << 36) + {1'b0, p_next[37:1]};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_GMUL;
            ST_GMUL: n_state = (r_len != 8'd0 && {8'd0, r_len} >= r_cnt) ? ST_GDIV : ST_SUM;
            ST_GDIV: if (r_step == 6'd23) n_state = ST_SUM;
            ST_SUM:  n_state = ST_ARG;
            ST_ARG:  n_state = (r_sum != signed'(r_last[r_voice])) ? ST_POLY : ST_OUT;
            ST_POLY: if (r_step == 6'd4) n_state = ST_PEND;
            ST_PEND: n_state = r_neg ? ST_RDIV : ST_OUT;
            ST_RDIV: if (r_step == 6'd37) n_state = ST_OUT;
            ST_OUT:  if (m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath and per-voice last sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICES; i++) r_last[i] <= RESET_SUM;
        end else begin
            case (r_state)
                ST_IDLE: if (s_axis_tvalid) begin
                    r_voice  <= s_axis_tdata[4:0];
                    r_target <= s_axis_tdata[20:5];
                    r_prev   <= s_axis_tdata[36:21];
                    r_len    <= s_axis_tdata[44:37];
                    r_cnt    <= s_axis_tdata[60:45];
                    r_offs   <= s_axis_tdata[76:61];
                    r_bend   <= s_axis_tdata[92:77];
                    r_note   <= s_axis_tdata[20:5];
                end
                ST_GMUL: begin
                    // |diff*cnt| fits 24 bits; load it at the top for division
                    r_neg  <= mul_p[67];
                    r_acc  <= {(mul_p[67] ? 24'(-mul_p) : 24'(mul_p)), 40'd0};
                    r_rem  <= '0;
                    r_step <= '0;
                end
                ST_GDIV: begin
                    r_step <= r_step + 6'd1;
                    r_rem  <= div_ge ? div_diff[37:0] : div_shift[37:0];
                    r_acc  <= {r_acc[62:0], div_ge};
                    if (r_step == 6'd23)
                        r_note <= 16'(17'(r_prev) + 17'(quo_s));
                end
                ST_SUM: r_sum <= signed'(sum_next);
                ST_ARG: begin
                    r_neg  <= r_sum[SUM_W-1];
                    r_a    <= mul_p[52:27];
                    r_v    <= 33'(poly_coef(3'd5));
                    r_step <= '0;
                    r_upd  <= 1'b0; r_clamp <= 1'b0; r_ratio <= '0;
                    if (r_sum != signed'(r_last[r_voice])) begin
                        r_last[r_voice] <= r_sum;
                        r_upd <= 1'b1;
                    end
                end
                ST_POLY: begin
                    r_step <= r_step + 6'd1;
                    r_v <= 33'(prod_rnd) + 33'(poly_coef(3'(3'd4 - r_step[2:0])));
                end
                ST_PEND: begin
                    // final product plus one; p fits 38 bits
                    r_p <= p_next;
                    if (!r_neg) begin
                        if (p_next > 38'({ONE_Q20, 1'b0})) begin
                            r_ratio <= RATIO_MAX; r_clamp <= 1'b1;
                        end else begin
                            r_ratio <= 18'((p_next + 38'd8) >> 4);
                        end
                    end
                    r_acc  <= {rdiv_num, 26'd0};
                    r_rem  <= '0;
                    r_step <= '0;
                end
                ST_RDIV: begin
                    r_step <= r_step + 6'd1;
                    r_rem  <= div_ge ? div_diff[37:0] : div_shift[37:0];
                    r_acc  <= {r_acc[62:0], div_ge};
                    if (r_step == 6'd37) r_ratio <= {r_acc[16:0], div_ge};
                end
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {4'd0, r_note, r_clamp, r_upd, r_ratio};

`ifndef SYNTH
    a_clamp_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[19] |-> m_axis_tdata[18]) else $error("clamp w/o update");
    a_noupd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[18] |-> m_axis_tdata[17:0] == 18'd0) else $error("ratio");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("ready during output");
`endif
endmodule
